@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising edge outside reset.
`define DRT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that expr never holds at a rising edge outside reset.
`define DRT_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

@@ rtl/drt_pkg.sv @@
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types, command and status codes for the record table.
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int RECORD_COUNT_DEF = 16;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int ID_W     = 16;
  localparam int TIME_W   = 32;
  localparam int TENTHS_W = 8;
  localparam int RAND_W   = 32;
  localparam int MILLIS_W = 15;

  localparam int MILLIS_SCALE = 100;
  localparam int MILLIS_MAX   = 25599;

  localparam int MOD_DIVISOR = 100;
  localparam int REM_W       = 7;
  localparam int MOD_SHIFT   = 37;

  localparam logic [RAND_W-1:0] MOD_RECIP = 32'h51eb_851f;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]     reader;
    logic [TIME_W-1:0]   stamp;
    logic [MILLIS_W-1:0] millis;
  } record_t;

endpackage

@@ rtl/drt_mod100.sv @@
// ----------------------------------------------------------------------------
// drt_mod100
// Remainder of a 32-bit word by 100 through a reciprocal multiply.
// ----------------------------------------------------------------------------
module drt_mod100 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [drt_pkg::RAND_W-1:0] value_i,
  output logic                       done_o,
  output logic [drt_pkg::REM_W-1:0]  rem_o
);

  localparam int PROD_W = 2 * drt_pkg::RAND_W;
  localparam int QUO_W  = PROD_W - drt_pkg::MOD_SHIFT;

  logic                        mul_q;
  logic                        sub_q;
  logic                        done_q;
  logic [drt_pkg::RAND_W-1:0]  value_q;
  logic [QUO_W-1:0]            quo_q;
  logic [drt_pkg::REM_W-1:0]   rem_q;
  logic [PROD_W-1:0]           prod;
  logic [drt_pkg::RAND_W-1:0]  back;
  logic [drt_pkg::RAND_W-1:0]  diff;

  always_comb begin
    prod = {{drt_pkg::RAND_W{1'b0}}, value_q} * {{drt_pkg::RAND_W{1'b0}}, drt_pkg::MOD_RECIP};
    back = drt_pkg::RAND_W'(quo_q) * drt_pkg::RAND_W'(drt_pkg::MOD_DIVISOR);
    diff = value_q - back;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= start_i;
      sub_q  <= mul_q;
      done_q <= sub_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      value_q <= value_i;
    end
    if (mul_q) begin
      quo_q <= prod[PROD_W-1:drt_pkg::MOD_SHIFT];
    end
    if (sub_q) begin
      rem_q <= diff[drt_pkg::REM_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/dedup_record_table.sv @@
// ----------------------------------------------------------------------------
// dedup_record_table
// Table of timing records with valid marks, id dedup on insert.
// ----------------------------------------------------------------------------
// The input channel carries one command per transaction: clear, insert,
// read first valid entry, or delete by reader id. Every transaction gives
// exactly one result transaction with a status and, for a successful read,
// the stored record; all other results carry zero record fields.
// One command is worked at a time; in_stall_o is high from acceptance until
// the result is loaded into the output register, so a new command is taken
// only after the last one is through. Steps per command:
//   clear  valid marks cleared at acceptance
//   read   valid-bit scan, one entry per cycle, then a read
//   delete id scan through the record memory port
//   insert remainder by 100, id scan, free scan
// The record memory has one read and one write port; the id scan uses it one
// entry per cycle. Reset clears all valid marks at once and empties the
// output register. A stalled result holds in the output register; the next
// command may be accepted meanwhile and waits before its own result load.
// ----------------------------------------------------------------------------
module dedup_record_table #(
  parameter int RECORD_COUNT = drt_pkg::RECORD_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [drt_pkg::CMD_W-1:0]    command_i,
  input  logic [drt_pkg::ID_W-1:0]     record_id_i,
  input  logic [drt_pkg::TIME_W-1:0]   utc_time_i,
  input  logic [drt_pkg::TENTHS_W-1:0] tenths_i,
  input  logic [drt_pkg::RAND_W-1:0]   random_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [drt_pkg::STATUS_W-1:0] status_o,
  output logic [drt_pkg::ID_W-1:0]     out_record_id_o,
  output logic [drt_pkg::TIME_W-1:0]   out_utc_time_o,
  output logic [drt_pkg::MILLIS_W-1:0] out_millis_o
);

`include "assert_macros.svh"

  localparam int IW = (RECORD_COUNT > 1) ? $clog2(RECORD_COUNT) : 1;
  localparam int CW = $clog2(RECORD_COUNT + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(RECORD_COUNT - 1);
  localparam logic [CW-1:0] CNT_END  = CW'(RECORD_COUNT);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_MOD        = 3'd1;
  localparam logic [2:0] S_ID_SCAN    = 3'd2;
  localparam logic [2:0] S_FREE_SCAN  = 3'd3;
  localparam logic [2:0] S_VALID_SCAN = 3'd4;
  localparam logic [2:0] S_READ_WAIT  = 3'd5;
  localparam logic [2:0] S_FINISH     = 3'd6;

  logic [2:0]                   state_q, state_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic                         rd_live_q, rd_live_d;
  logic [RECORD_COUNT-1:0]      valid_q, valid_d;
  logic                         out_valid_q, out_valid_d;

  logic [drt_pkg::CMD_W-1:0]    cmd_q;
  logic [drt_pkg::ID_W-1:0]     rid_q;
  logic [drt_pkg::TIME_W-1:0]   utc_q;
  logic [drt_pkg::TENTHS_W-1:0] tenths_q;

  logic [drt_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  drt_pkg::record_t             res_rec_q, res_rec_d;
  logic [drt_pkg::STATUS_W-1:0] out_status_q;
  drt_pkg::record_t             out_rec_q;

  drt_pkg::record_t             mem [RECORD_COUNT];
  drt_pkg::record_t             rd_data_q;
  drt_pkg::record_t             wr_rec;
  logic [IW-1:0]                rd_idx_q;
  logic [IW-1:0]                rd_addr;
  logic                         rd_en;
  logic                         wr_en;

  logic                         in_accept;
  logic                         out_load;
  logic [IW-1:0]                scan_idx;
  logic                         scan_valid;
  logic                         scan_last;
  logic                         id_hit;
  logic                         id_last;

  logic                         mod_start;
  logic                         mod_done;
  logic [drt_pkg::REM_W-1:0]    mod_rem;
  logic [drt_pkg::MILLIS_W-1:0] millis_calc;

  drt_mod100 u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (random_value_i),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_FINISH) && (!out_valid_q || !out_stall_i);

  assign scan_idx   = cnt_q[IW-1:0];
  assign scan_valid = valid_q[scan_idx];
  assign scan_last  = (scan_idx == LAST_IDX);
  assign id_hit     = rd_live_q && valid_q[rd_idx_q] && (rd_data_q.reader == rid_q);
  assign id_last    = rd_live_q && (rd_idx_q == LAST_IDX);

  assign millis_calc = drt_pkg::MILLIS_W'(tenths_q) * drt_pkg::MILLIS_W'(drt_pkg::MILLIS_SCALE)
                     + drt_pkg::MILLIS_W'(mod_rem);

  always_comb begin
    wr_rec.reader = rid_q;
    wr_rec.stamp  = utc_q;
    wr_rec.millis = millis_calc;
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rd_live_d    = 1'b0;
    valid_d      = valid_q;
    res_status_d = res_status_q;
    res_rec_d    = res_rec_q;
    rd_en        = 1'b0;
    rd_addr      = scan_idx;
    wr_en        = 1'b0;
    mod_start    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          res_rec_d = '0;
          cnt_d     = '0;
          case (command_i)
            drt_pkg::CMD_CLEAR: begin
              valid_d      = '0;
              res_status_d = drt_pkg::ST_DONE;
              state_d      = S_FINISH;
            end
            drt_pkg::CMD_INSERT: begin
              mod_start = 1'b1;
              state_d   = S_MOD;
            end
            drt_pkg::CMD_READ: begin
              state_d = S_VALID_SCAN;
            end
            default: begin
              state_d = S_ID_SCAN;
            end
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_d = S_ID_SCAN;
        end
      end
      S_ID_SCAN: begin
        rd_en     = (cnt_q < CNT_END);
        rd_live_d = rd_en;
        if (rd_en) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (id_hit) begin
          rd_live_d = 1'b0;
          state_d   = S_FINISH;
          if (cmd_q == drt_pkg::CMD_INSERT) begin
            res_status_d = drt_pkg::ST_DUP;
          end else begin
            valid_d[rd_idx_q] = 1'b0;
            res_status_d      = drt_pkg::ST_DONE;
          end
        end else if (id_last) begin
          rd_live_d = 1'b0;
          cnt_d     = '0;
          if (cmd_q == drt_pkg::CMD_INSERT) begin
            state_d = S_FREE_SCAN;
          end else begin
            res_status_d = drt_pkg::ST_NONE;
            state_d      = S_FINISH;
          end
        end
      end
      S_FREE_SCAN: begin
        if (!scan_valid) begin
          wr_en             = 1'b1;
          valid_d[scan_idx] = 1'b1;
          res_status_d      = drt_pkg::ST_DONE;
          state_d           = S_FINISH;
        end else if (scan_last) begin
          res_status_d = drt_pkg::ST_FULL;
          state_d      = S_FINISH;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_VALID_SCAN: begin
        if (scan_valid) begin
          rd_en   = 1'b1;
          state_d = S_READ_WAIT;
        end else if (scan_last) begin
          res_status_d = drt_pkg::ST_NONE;
          state_d      = S_FINISH;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_READ_WAIT: begin
        res_rec_d    = rd_data_q;
        res_status_d = drt_pkg::ST_DONE;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_live_q   <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_live_q   <= rd_live_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q    <= command_i;
      rid_q    <= record_id_i;
      utc_q    <= utc_time_i;
      tenths_q <= tenths_i;
    end
    res_status_q <= res_status_d;
    res_rec_q    <= res_rec_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_rec_q    <= res_rec_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[scan_idx] <= wr_rec;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_idx_q  <= rd_addr;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign out_record_id_o = out_rec_q.reader;
  assign out_utc_time_o  = out_rec_q.stamp;
  assign out_millis_o    = out_rec_q.millis;

  `DRT_ASSERT(a_result_from_finish, clk_i, rst_ni,
              $rose(out_valid_q) |-> $past(state_q == S_FINISH))
  `DRT_ASSERT(a_fields_zero_unless_read, clk_i, rst_ni,
              (out_valid_o && status_o != drt_pkg::ST_DONE) |->
              (out_record_id_o == '0 && out_utc_time_o == '0 && out_millis_o == '0))
  `DRT_ASSERT_NEVER(a_millis_range, clk_i, rst_ni,
                    out_valid_o && (out_millis_o > drt_pkg::MILLIS_W'(drt_pkg::MILLIS_MAX)))
  `DRT_ASSERT(a_insert_adds_one, clk_i, rst_ni,
              wr_en |=> ($countones(valid_q) == $past($countones(valid_q)) + 1))

endmodule

@@ test/tb_dedup_record_table.sv @@
// ----------------------------------------------------------------------------
// tb_dedup_record_table
// Self-checking bench for the deduplicating record table.
// ----------------------------------------------------------------------------
// Drives clear, insert, read and delete commands into the block and predicts
// every result from a private copy of the table: valid marks, reader ids,
// time stamps and millisecond values. A short directed run covers the empty
// and full table, duplicate ids and the field extremes. The random run then
// mixes commands over a small pool of reader ids, so that duplicates, hits on
// delete and full tables come up often. Both sides idle and stall at random
// in several phases. One long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_dedup_record_table;
  import drt_pkg::*;

  localparam int TABLE_DEPTH    = RECORD_COUNT_DEF;
  localparam int PHASE_ITEMS    = 250;
  localparam int ID_POOL_SIZE   = 20;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 2 * TABLE_DEPTH + 60;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     reader;
    logic [TIME_W-1:0]   stamp;
    logic [MILLIS_W-1:0] millis;
  } table_result_t;

  class record_table_tracker;
    bit                  entry_used[TABLE_DEPTH];
    logic [ID_W-1:0]     entry_reader[TABLE_DEPTH];
    logic [TIME_W-1:0]   entry_stamp[TABLE_DEPTH];
    logic [MILLIS_W-1:0] entry_millis[TABLE_DEPTH];
    table_result_t       expected_results[$];
    int                  error_count;

    function new();
      foreach (entry_used[k]) entry_used[k] = 1'b0;
      error_count = 0;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                               logic [TIME_W-1:0] utc, logic [TENTHS_W-1:0] tenths,
                               logic [RAND_W-1:0] rnd);
      table_result_t       res;
      int                  hit;
      int                  free_slot;
      int                  first_used;
      logic [MILLIS_W-1:0] ms;
      res        = '0;
      res.status = ST_DONE;
      hit        = -1;
      free_slot  = -1;
      first_used = -1;
      ms = MILLIS_W'(32'(tenths) * 32'(MILLIS_SCALE) + (rnd % 32'(MOD_DIVISOR)));
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        if (entry_used[k] && entry_reader[k] == id && hit < 0) hit = k;
        if (!entry_used[k] && free_slot < 0) free_slot = k;
        if (entry_used[k] && first_used < 0) first_used = k;
      end
      case (cmd)
        CMD_CLEAR: begin
          foreach (entry_used[k]) entry_used[k] = 1'b0;
        end
        CMD_INSERT: begin
          if (hit >= 0) begin
            res.status = ST_DUP;
          end else if (free_slot < 0) begin
            res.status = ST_FULL;
          end else begin
            entry_used[free_slot]   = 1'b1;
            entry_reader[free_slot] = id;
            entry_stamp[free_slot]  = utc;
            entry_millis[free_slot] = ms;
          end
        end
        CMD_READ: begin
          if (first_used < 0) begin
            res.status = ST_NONE;
          end else begin
            res.reader = entry_reader[first_used];
            res.stamp  = entry_stamp[first_used];
            res.millis = entry_millis[first_used];
          end
        end
        default: begin
          if (hit < 0) res.status = ST_NONE;
          else entry_used[hit] = 1'b0;
        end
      endcase
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        error_count++;
      end
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, actual %0h", $time, got);
        error_count++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("out_record_id", 64'(want.reader), 64'(got.reader));
      compare_field("out_utc_time", 64'(want.stamp), 64'(got.stamp));
      compare_field("out_millis", 64'(want.millis), 64'(got.millis));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CMD_W-1:0]    command_i;
  logic [ID_W-1:0]     record_id_i;
  logic [TIME_W-1:0]   utc_time_i;
  logic [TENTHS_W-1:0] tenths_i;
  logic [RAND_W-1:0]   random_value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [STATUS_W-1:0] status_o;
  logic [ID_W-1:0]     out_record_id_o;
  logic [TIME_W-1:0]   out_utc_time_o;
  logic [MILLIS_W-1:0] out_millis_o;

  record_table_tracker tracker = new();
  logic [ID_W-1:0]     id_pool[ID_POOL_SIZE];
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  int                  hold_left = 0;
  int                  quiet_cycles = 0;

  dedup_record_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .record_id_i    (record_id_i),
    .utc_time_i     (utc_time_i),
    .tenths_i       (tenths_i),
    .random_value_i (random_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_record_id_o(out_record_id_o),
    .out_utc_time_o (out_utc_time_o),
    .out_millis_o   (out_millis_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hold off for a counted stretch on request, else stall at random
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_result('{status_o, out_record_id_o, out_utc_time_o, out_millis_o});
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("dedup_record_table: mismatch");
        $finish;
      end
    end
  end

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                           logic [TIME_W-1:0] utc, logic [TENTHS_W-1:0] tenths,
                           logic [RAND_W-1:0] rnd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    command_i      = cmd;
    record_id_i    = id;
    utc_time_i     = utc;
    tenths_i       = tenths;
    random_value_i = rnd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_command(cmd, id, utc, tenths, rnd);
    @(negedge clk_i);
  endtask

  task automatic send_random_item();
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
    int               pick;
    pick = $urandom_range(99);
    if (pick < 2) cmd = CMD_CLEAR;
    else if (pick < 50) cmd = CMD_INSERT;
    else if (pick < 68) cmd = CMD_READ;
    else cmd = CMD_DELETE;
    if ($urandom_range(99) < 80) id = id_pool[$urandom_range(ID_POOL_SIZE - 1)];
    else id = ID_W'($urandom);
    send_item(cmd, id, $urandom, TENTHS_W'($urandom_range(255)), $urandom);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = CMD_CLEAR;
    record_id_i    = '0;
    utc_time_i     = '0;
    tenths_i       = '0;
    random_value_i = '0;
    foreach (id_pool[k]) id_pool[k] = ID_W'($urandom);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(CMD_CLEAR, '0, '0, '0, '0);
    send_item(CMD_READ, '0, '0, '0, '0);
    send_item(CMD_DELETE, 16'h1234, '0, '0, '0);
    send_item(CMD_INSERT, '1, '1, '1, '1);
    send_item(CMD_INSERT, '0, '0, '0, '0);
    send_item(CMD_INSERT, '1, 32'h0bad_cafe, 8'd7, 32'd99);
    send_item(CMD_READ, '1, '1, '1, '1);
    send_item(CMD_DELETE, '1, '0, '0, '0);
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      send_item(CMD_INSERT, ID_W'(16'h1000 + k), $urandom,
                TENTHS_W'($urandom_range(255)), $urandom);
    end
    send_item(CMD_INSERT, 16'h5a5a, '1, 8'd255, 32'd100);
    send_item(CMD_DELETE, '0, '0, '0, '0);
    send_item(CMD_READ, '0, '0, '0, '0);
    send_item(CMD_CLEAR, '1, '1, '1, '1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          hold_left     = HOLD_CYCLES;
        end
        1: begin
          send_idle_pct = 62;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 62;
        end
        default: begin
          send_idle_pct = 31;
          stall_pct     = 31;
        end
      endcase
      repeat (PHASE_ITEMS) send_random_item();
    end

    in_valid_i    = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.error_count == 0) begin
      $display("dedup_record_table: match");
    end else begin
      $display("dedup_record_table: mismatch");
    end
    $finish;
  end

endmodule
